[src/pixel_to_ground_plane_unit_macros.svh]
// Assertion macros for the pixel to ground plane unit.
`ifndef PIXEL_TO_GROUND_PLANE_UNIT_MACROS_SVH
`define PIXEL_TO_GROUND_PLANE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// check that a holds b in the same cycle
`define PTGP_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: label");
// check that a holds b in the next cycle
`define PTGP_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: label");
`else
`define PTGP_ASSERT_IMPLY(label, clk, rst, a, b)
`define PTGP_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[src/ptgp_pkg.sv]
// Shared constants and types of the pixel to ground plane unit.
package ptgp_pkg;
   localparam int PIXEL_BITS = 12;
   localparam int FRAC_BITS  = 16;
   localparam int COEF_W     = 32;
   localparam int QBITS      = 32;
   localparam int NUM_REGS   = 8;
   localparam int IDX_W      = $clog2(NUM_REGS);
   localparam int ADDR_W     = IDX_W + 2;
   // signed coefficient times zero-extended pixel
   localparam int PROD_W     = COEF_W + PIXEL_BITS + 1;
   // sum of three terms
   localparam int SUM_W      = PROD_W + 2;
   // remainder and shifted divisor width of the division chain
   localparam int DIV_W      = SUM_W + QBITS;

   localparam logic [IDX_W-1:0] REG_H00 = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_H01 = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_H02 = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_H10 = IDX_W'(3);
   localparam logic [IDX_W-1:0] REG_H11 = IDX_W'(4);
   localparam logic [IDX_W-1:0] REG_H12 = IDX_W'(5);
   localparam logic [IDX_W-1:0] REG_H20 = IDX_W'(6);
   localparam logic [IDX_W-1:0] REG_H21 = IDX_W'(7);

   localparam logic [COEF_W-1:0] ONE_Q = COEF_W'(1) << FRAC_BITS;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef coef_type coef_bank_type [NUM_REGS];

   // payload handed from cell to cell
   typedef struct packed {
      logic [DIV_W-1:0] rem_x;
      logic [DIV_W-1:0] rem_y;
      logic [DIV_W-1:0] dsh;
      logic [QBITS-1:0] qx;
      logic [QBITS-1:0] qy;
      logic             neg_x;
      logic             neg_y;
      logic             ovf_x;
      logic             ovf_y;
      logic             horizon;
   } div_type;
endpackage

[src/pixel_to_ground_plane_unit.sv]
// Top: ground-plane homography projection, one pixel per clock unless stalled.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_pixel_u, req_pixel_v
//   rsp      out        rsp_valid/rsp_stall  rsp_world_x, rsp_world_y, flags
//   csr      in         psel/penable/pwrite  paddr, pwdata, prdata
//
// One transaction is accepted per clock while req_stall is low. The pipeline
// has three front stages (multiply, sum, magnitude), one division cell per
// quotient bit (32), and the output register. Empty stages close up under
// rsp_stall, so req_stall rises only when every stage is full. Reset clears
// valid bits and loads the identity homography.
`include "pixel_to_ground_plane_unit_macros.svh"
module pixel_to_ground_plane_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ptgp_pkg::PIXEL_BITS-1:0] req_pixel_u,
   input  logic [ptgp_pkg::PIXEL_BITS-1:0] req_pixel_v,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [31:0]              rsp_world_x,
   output logic signed [31:0]              rsp_world_y,
   output logic                            rsp_at_horizon,
   output logic                            rsp_saturated,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ptgp_pkg::ADDR_W-1:0]     paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   localparam int QB = ptgp_pkg::QBITS;

   typedef struct packed {
      logic [QB-1:0] val;
      logic          sat;
   } coord_type;

   ptgp_pkg::coef_bank_type coef_ff;
   logic [ptgp_pkg::IDX_W-1:0] widx;

   ptgp_pkg::div_type chain_data [QB+1];
   logic              chain_valid [QB+1];
   logic              chain_go [QB+1];
   logic              front_go;

   logic              rsp_valid_ff;
   logic [QB-1:0]     x_ff, y_ff;
   logic              horizon_ff, sat_ff;
   coord_type         cx, cy;

   // clip a magnitude quotient to the signed range and apply the sign
   function automatic coord_type finish(input logic [QB-1:0] q, input logic neg,
                                        input logic ovf);
      coord_type r;
      logic      big;
      big = ovf || (neg ? (q[QB-1] && (q[QB-2:0] != '0)) : q[QB-1]);
      r.sat = big;
      if (big) begin
         r.val = neg ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
      end else begin
         r.val = neg ? QB'(-q) : q;
      end
      return r;
   endfunction

   // register file writes
   assign pready = 1'b1;
   assign widx   = paddr[ptgp_pkg::ADDR_W-1:2];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ptgp_pkg::NUM_REGS; i++) begin
            if (ptgp_pkg::IDX_W'(i) == ptgp_pkg::REG_H00 ||
                ptgp_pkg::IDX_W'(i) == ptgp_pkg::REG_H11) begin
               coef_ff[i] <= ptgp_pkg::ONE_Q;
            end else begin
               coef_ff[i] <= '0;
            end
         end
      end else if (psel && penable && pwrite) begin
         coef_ff[widx] <= pwdata;
      end
   end
   assign prdata = coef_ff[widx];

   ptgp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_u      (req_pixel_u),
      .in_v      (req_pixel_v),
      .coef      (coef_ff),
      .in_go     (front_go),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0]),
      .out_go    (chain_go[0])
   );
   assign req_stall = !front_go;

   // division chain, most significant quotient bit first
   for (genvar i = 0; i < QB; i++) begin : g_cell
      ptgp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .in_go     (chain_go[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1]),
         .out_go    (chain_go[i+1])
      );
   end

   // output register: hold while stalled
   assign chain_go[QB] = !rsp_valid_ff || !rsp_stall;
   assign cx = finish(chain_data[QB].qx, chain_data[QB].neg_x, chain_data[QB].ovf_x);
   assign cy = finish(chain_data[QB].qy, chain_data[QB].neg_y, chain_data[QB].ovf_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chain_go[QB]) begin
         rsp_valid_ff <= chain_valid[QB];
      end
      if (chain_go[QB]) begin
         horizon_ff <= chain_data[QB].horizon;
         x_ff       <= chain_data[QB].horizon ? '0 : cx.val;
         y_ff       <= chain_data[QB].horizon ? '0 : cy.val;
         sat_ff     <= !chain_data[QB].horizon && (cx.sat || cy.sat);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_world_x    = x_ff;
   assign rsp_world_y    = y_ff;
   assign rsp_at_horizon = horizon_ff;
   assign rsp_saturated  = sat_ff;

   `PTGP_ASSERT_IMPLY(a_horizon_zero, clock, reset, rsp_valid && rsp_at_horizon, rsp_world_x == 0 && rsp_world_y == 0 && !rsp_saturated)
   `PTGP_ASSERT_IMPLY(a_stall_full, clock, reset, req_stall, rsp_valid && rsp_stall)
   `PTGP_ASSERT_IMPLY(a_sat_clipped, clock, reset, rsp_valid && rsp_saturated, rsp_world_x == 32'sh7fffffff || rsp_world_x == 32'sh80000000 || rsp_world_y == 32'sh7fffffff || rsp_world_y == 32'sh80000000)
endmodule

[src/ptgp_front.sv]
// Front end: products, sums, magnitudes and overflow check of one pixel.
module ptgp_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [ptgp_pkg::PIXEL_BITS-1:0] in_u,
   input  logic [ptgp_pkg::PIXEL_BITS-1:0] in_v,
   input  ptgp_pkg::coef_bank_type         coef,
   output logic                            in_go,
   output logic                            out_valid,
   output ptgp_pkg::div_type               out_data,
   input  logic                            out_go
);
   localparam int PW = ptgp_pkg::PROD_W;
   localparam int SW = ptgp_pkg::SUM_W;
   localparam int DW = ptgp_pkg::DIV_W;

   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                 go1, go2, go3;
   logic signed [PW-1:0] prod_ff [6];
   logic signed [SW-1:0] c02_ff, c12_ff;
   logic signed [SW-1:0] nx_ff, ny_ff, den_ff;
   logic signed [PW-1:0] su, sv;
   logic [SW-1:0]        mx, my, md;
   ptgp_pkg::div_type    out_in;
   ptgp_pkg::div_type    out_ff;

   // advance each stage when it is empty or the next one moves
   assign go3   = !s3_valid_ff || out_go;
   assign go2   = !s2_valid_ff || go3;
   assign go1   = !s1_valid_ff || go2;
   assign in_go = go1;

   assign su = PW'($signed({1'b0, in_u}));
   assign sv = PW'($signed({1'b0, in_v}));

   // stage one: multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (go1) begin
         s1_valid_ff <= in_valid;
      end
      if (go1) begin
         prod_ff[0] <= PW'(coef[ptgp_pkg::REG_H00]) * su;
         prod_ff[1] <= PW'(coef[ptgp_pkg::REG_H01]) * sv;
         prod_ff[2] <= PW'(coef[ptgp_pkg::REG_H10]) * su;
         prod_ff[3] <= PW'(coef[ptgp_pkg::REG_H11]) * sv;
         prod_ff[4] <= PW'(coef[ptgp_pkg::REG_H20]) * su;
         prod_ff[5] <= PW'(coef[ptgp_pkg::REG_H21]) * sv;
         c02_ff     <= SW'(coef[ptgp_pkg::REG_H02]);
         c12_ff     <= SW'(coef[ptgp_pkg::REG_H12]);
      end
   end

   // stage two: sum numerators and denominator
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (go2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (go2) begin
         nx_ff  <= SW'(prod_ff[0]) + SW'(prod_ff[1]) + c02_ff;
         ny_ff  <= SW'(prod_ff[2]) + SW'(prod_ff[3]) + c12_ff;
         den_ff <= SW'(prod_ff[4]) + SW'(prod_ff[5])
                   + SW'($signed({1'b0, ptgp_pkg::ONE_Q}));
      end
   end

   // stage three: magnitudes, signs and quotient overflow
   always_comb begin
      mx = nx_ff[SW-1]  ? SW'(-nx_ff)  : SW'(nx_ff);
      my = ny_ff[SW-1]  ? SW'(-ny_ff)  : SW'(ny_ff);
      md = den_ff[SW-1] ? SW'(-den_ff) : SW'(den_ff);
      out_in.rem_x   = DW'(mx) << ptgp_pkg::FRAC_BITS;
      out_in.rem_y   = DW'(my) << ptgp_pkg::FRAC_BITS;
      out_in.dsh     = DW'(md) << (ptgp_pkg::QBITS - 1);
      out_in.qx      = '0;
      out_in.qy      = '0;
      out_in.neg_x   = nx_ff[SW-1] ^ den_ff[SW-1];
      out_in.neg_y   = ny_ff[SW-1] ^ den_ff[SW-1];
      out_in.ovf_x   = (DW'(mx) << ptgp_pkg::FRAC_BITS) >= (DW'(md) << ptgp_pkg::QBITS);
      out_in.ovf_y   = (DW'(my) << ptgp_pkg::FRAC_BITS) >= (DW'(md) << ptgp_pkg::QBITS);
      out_in.horizon = (den_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (go3) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (go3) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = out_ff;
endmodule

[src/ptgp_cell.sv]
// One restoring division cell: settles one quotient bit of both coordinates.
module ptgp_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ptgp_pkg::div_type in_data,
   output logic              in_go,
   output logic              out_valid,
   output ptgp_pkg::div_type out_data,
   input  logic              out_go
);
   localparam int QB = ptgp_pkg::QBITS;

   logic              valid_ff;
   ptgp_pkg::div_type data_ff;
   ptgp_pkg::div_type data_in;
   logic              take_x, take_y;

   assign in_go = !valid_ff || out_go;

   // subtract the shifted divisor where it fits, then halve it
   always_comb begin
      take_x          = in_data.rem_x >= in_data.dsh;
      take_y          = in_data.rem_y >= in_data.dsh;
      data_in         = in_data;
      data_in.rem_x   = take_x ? in_data.rem_x - in_data.dsh : in_data.rem_x;
      data_in.rem_y   = take_y ? in_data.rem_y - in_data.dsh : in_data.rem_y;
      data_in.qx      = {in_data.qx[QB-2:0], take_x};
      data_in.qy      = {in_data.qy[QB-2:0], take_y};
      data_in.dsh     = in_data.dsh >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_go) begin
         valid_ff <= in_valid;
      end
      if (in_go) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
